@@ rtl/core/mwem_pkg.sv @@
// Shared types and constants for the three-wire serial EEPROM master.
// Used by mwem_seq and microwire_eeprom_master_top; depends on nothing.
package mwem_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned WORD_W  = 19;
  localparam int unsigned BCNT_W  = 5;
  localparam int unsigned POLL_W  = 6;
  localparam int unsigned ATT_W   = 3;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd5;

  localparam logic [1:0] OP_CONTROL = 2'b00;
  localparam logic [1:0] OP_WRITE   = 2'b01;
  localparam logic [1:0] OP_READ    = 2'b10;

  localparam logic [ADDR_W-1:0] ADDR_ENABLE  = 8'hC0;
  localparam logic [ADDR_W-1:0] ADDR_DISABLE = 8'h00;
  localparam logic [ADDR_W-1:0] ADDR_ERASE   = 8'h80;

  localparam logic [BCNT_W-1:0] BITS_SHORT = 5'd11;
  localparam logic [BCNT_W-1:0] BITS_WRITE = 5'd19;
  localparam logic [BCNT_W-1:0] BITS_RECV  = 5'd8;

  localparam logic [ATT_W-1:0]  ATTEMPT_RESET = 3'd3;
  localparam logic [POLL_W-1:0] POLL_RESET    = 6'd20;

  localparam logic CFG_ATTEMPT = 1'b0;
  localparam logic CFG_POLL    = 1'b1;

  typedef enum logic [1:0] {
    KIND_CONTROL = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_READ    = 2'd2
  } kind_t;

  typedef struct packed {
    logic              write_failed;
    logic [DATA_W-1:0] rx_byte;
    logic              done_res;
    logic              busy_res;
    logic              serial_out;
    logic              serial_clock;
    logic              chip_select;
  } res_t;

endpackage

@@ rtl/core/mwem_seq.sv @@
// Pin sequencer of the serial EEPROM master: frame state and per-tick pin levels.
// Depends on mwem_pkg; advanced by one tick on every step strobe.
module mwem_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [mwem_pkg::CMD_W-1:0]          command,
  input  logic [mwem_pkg::ADDR_W-1:0]         address,
  input  logic [mwem_pkg::DATA_W-1:0]         write_data,
  input  logic                                serial_in,
  input  logic [mwem_pkg::ATT_W-1:0]          attempt_limit,
  input  logic [mwem_pkg::POLL_W-1:0]         ready_poll_limit,
  output mwem_pkg::res_t                      res
);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SEND_HI    = 4'd1,
    PH_SEND_LO    = 4'd2,
    PH_RECV_HI    = 4'd3,
    PH_RECV_LO    = 4'd4,
    PH_POLL_FIRST = 4'd5,
    PH_POLL       = 4'd6,
    PH_GAP_ENABLE = 4'd7,
    PH_GAP_WRITE  = 4'd8,
    PH_GAP_POLL   = 4'd9,
    PH_GAP_RETRY  = 4'd10,
    PH_FINISH     = 4'd11
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [mwem_pkg::BCNT_W-1:0]     bit_count_r, bit_count_nxt;
  logic [mwem_pkg::WORD_W-1:0]     shift_word_r, shift_word_nxt;
  logic [mwem_pkg::POLL_W-1:0]     poll_count_r, poll_count_nxt;
  logic [mwem_pkg::ATT_W-1:0]      attempt_count_r, attempt_count_nxt;
  logic [mwem_pkg::CMD_W-1:0]      held_command_r, held_command_nxt;
  logic [mwem_pkg::ADDR_W-1:0]     held_address_r, held_address_nxt;
  logic [mwem_pkg::DATA_W-1:0]     held_data_r, held_data_nxt;
  logic [mwem_pkg::DATA_W-1:0]     received_byte_r, received_byte_nxt;
  mwem_pkg::kind_t                 frame_kind_r, frame_kind_nxt;
  logic                            failed_r, failed_nxt;

  logic [mwem_pkg::ATT_W-1:0]      limit;
  logic [mwem_pkg::ATT_W-1:0]      attempt_inc;
  logic [mwem_pkg::BCNT_W-1:0]     bit_dec;
  logic [mwem_pkg::WORD_W-1:0]     recv_word;
  logic                            held_is_write;
  logic                            cs, sclk, dout, busy, done;

  function automatic logic [mwem_pkg::WORD_W-1:0] short_word(
    input logic [1:0]                  op,
    input logic [mwem_pkg::ADDR_W-1:0] addr
  );
    return {1'b1, op, addr, {mwem_pkg::DATA_W{1'b0}}};
  endfunction

  assign limit         = (attempt_limit == '0) ? mwem_pkg::ATT_W'(1) : attempt_limit;
  assign attempt_inc   = attempt_count_r + mwem_pkg::ATT_W'(1);
  assign bit_dec       = (bit_count_r != '0) ? bit_count_r - mwem_pkg::BCNT_W'(1) : '0;
  assign recv_word     = {{(mwem_pkg::WORD_W-mwem_pkg::DATA_W){1'b0}},
                          shift_word_r[mwem_pkg::DATA_W-2:0], serial_in};
  assign held_is_write = (held_command_r == mwem_pkg::CMD_WRITE);

  always_comb begin
    phase_nxt         = phase_r;
    bit_count_nxt     = bit_count_r;
    shift_word_nxt    = shift_word_r;
    poll_count_nxt    = poll_count_r;
    attempt_count_nxt = attempt_count_r;
    held_command_nxt  = held_command_r;
    held_address_nxt  = held_address_r;
    held_data_nxt     = held_data_r;
    received_byte_nxt = received_byte_r;
    frame_kind_nxt    = frame_kind_r;
    failed_nxt        = failed_r;
    cs   = 1'b0;
    sclk = 1'b0;
    dout = 1'b0;
    busy = 1'b1;
    done = 1'b0;
    unique case (phase_r)
      PH_SEND_HI: begin
        cs = 1'b1;
        sclk = 1'b1;
        dout = shift_word_r[mwem_pkg::WORD_W-1];
        phase_nxt = PH_SEND_LO;
      end
      PH_SEND_LO: begin
        cs = 1'b1;
        dout = shift_word_r[mwem_pkg::WORD_W-1];
        shift_word_nxt = {shift_word_r[mwem_pkg::WORD_W-2:0], 1'b0};
        bit_count_nxt = bit_dec;
        if (bit_dec == '0) begin
          priority if (frame_kind_r == mwem_pkg::KIND_READ) begin
            shift_word_nxt = '0;
            bit_count_nxt = mwem_pkg::BITS_RECV;
            phase_nxt = PH_RECV_HI;
          end else if (frame_kind_r == mwem_pkg::KIND_WRITE) begin
            phase_nxt = PH_GAP_WRITE;
          end else begin
            phase_nxt = held_is_write ? PH_GAP_ENABLE : PH_FINISH;
          end
        end
      end
      PH_RECV_HI: begin
        cs = 1'b1;
        sclk = 1'b1;
        phase_nxt = PH_RECV_LO;
      end
      PH_RECV_LO: begin
        cs = 1'b1;
        shift_word_nxt = recv_word;
        bit_count_nxt = bit_dec;
        if (bit_dec == '0) begin
          received_byte_nxt = recv_word[mwem_pkg::DATA_W-1:0];
          priority if (!held_is_write) begin
            phase_nxt = PH_FINISH;
          end else if (recv_word[mwem_pkg::DATA_W-1:0] == held_data_r) begin
            failed_nxt = 1'b0;
            phase_nxt = PH_FINISH;
          end else begin
            attempt_count_nxt = attempt_inc;
            if (attempt_inc >= limit || attempt_inc == '0) begin
              failed_nxt = 1'b1;
              phase_nxt = PH_FINISH;
            end else begin
              phase_nxt = PH_GAP_RETRY;
            end
          end
        end else begin
          phase_nxt = PH_RECV_HI;
        end
      end
      PH_POLL_FIRST: begin
        cs = 1'b1;
        if (serial_in) begin
          phase_nxt = PH_GAP_POLL;
        end else begin
          poll_count_nxt = '0;
          phase_nxt = PH_POLL;
        end
      end
      PH_POLL: begin
        cs = 1'b1;
        if (serial_in || poll_count_r >= ready_poll_limit) begin
          phase_nxt = PH_GAP_POLL;
        end else begin
          poll_count_nxt = poll_count_r + mwem_pkg::POLL_W'(1);
        end
      end
      PH_GAP_ENABLE: begin
        shift_word_nxt = {1'b1, mwem_pkg::OP_WRITE, held_address_r, held_data_r};
        bit_count_nxt = mwem_pkg::BITS_WRITE;
        frame_kind_nxt = mwem_pkg::KIND_WRITE;
        phase_nxt = PH_SEND_HI;
      end
      PH_GAP_WRITE: begin
        phase_nxt = PH_POLL_FIRST;
      end
      PH_GAP_POLL: begin
        shift_word_nxt = short_word(mwem_pkg::OP_READ, held_address_r);
        bit_count_nxt = mwem_pkg::BITS_SHORT;
        frame_kind_nxt = mwem_pkg::KIND_READ;
        phase_nxt = PH_SEND_HI;
      end
      PH_GAP_RETRY: begin
        shift_word_nxt = short_word(mwem_pkg::OP_CONTROL, mwem_pkg::ADDR_ENABLE);
        bit_count_nxt = mwem_pkg::BITS_SHORT;
        frame_kind_nxt = mwem_pkg::KIND_CONTROL;
        phase_nxt = PH_SEND_HI;
      end
      PH_FINISH: begin
        busy = 1'b0;
        done = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        busy = 1'b0;
        phase_nxt = PH_IDLE;
        if (command >= mwem_pkg::CMD_READ && command <= mwem_pkg::CMD_ERASE) begin
          held_command_nxt = command;
          held_address_nxt = address;
          held_data_nxt = write_data;
          attempt_count_nxt = '0;
          poll_count_nxt = '0;
          bit_count_nxt = mwem_pkg::BITS_SHORT;
          frame_kind_nxt = mwem_pkg::KIND_CONTROL;
          phase_nxt = PH_SEND_HI;
          priority if (command == mwem_pkg::CMD_READ) begin
            shift_word_nxt = short_word(mwem_pkg::OP_READ, address);
            frame_kind_nxt = mwem_pkg::KIND_READ;
          end else if (command == mwem_pkg::CMD_WRITE) begin
            failed_nxt = 1'b0;
            shift_word_nxt = short_word(mwem_pkg::OP_CONTROL, mwem_pkg::ADDR_ENABLE);
          end else if (command == mwem_pkg::CMD_ENABLE) begin
            shift_word_nxt = short_word(mwem_pkg::OP_CONTROL, mwem_pkg::ADDR_ENABLE);
          end else if (command == mwem_pkg::CMD_DISABLE) begin
            shift_word_nxt = short_word(mwem_pkg::OP_CONTROL, mwem_pkg::ADDR_DISABLE);
          end else begin
            shift_word_nxt = short_word(mwem_pkg::OP_CONTROL, mwem_pkg::ADDR_ERASE);
          end
        end
      end
    endcase
  end

  always_comb begin
    res.chip_select  = cs;
    res.serial_clock = sclk;
    res.serial_out   = dout;
    res.busy_res     = busy;
    res.done_res     = done;
    res.rx_byte      = received_byte_r;
    res.write_failed = failed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      bit_count_r     <= '0;
      shift_word_r    <= '0;
      poll_count_r    <= '0;
      attempt_count_r <= '0;
      held_command_r  <= mwem_pkg::CMD_NONE;
      held_address_r  <= '0;
      held_data_r     <= '0;
      received_byte_r <= '0;
      frame_kind_r    <= mwem_pkg::KIND_CONTROL;
      failed_r        <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      bit_count_r     <= bit_count_nxt;
      shift_word_r    <= shift_word_nxt;
      poll_count_r    <= poll_count_nxt;
      attempt_count_r <= attempt_count_nxt;
      held_command_r  <= held_command_nxt;
      held_address_r  <= held_address_nxt;
      held_data_r     <= held_data_nxt;
      received_byte_r <= received_byte_nxt;
      frame_kind_r    <= frame_kind_nxt;
      failed_r        <= failed_nxt;
    end
  end

endmodule

@@ rtl/core/microwire_eeprom_master_top.sv @@
// Top level of the three-wire serial EEPROM master: stream ports, registers,
// output register. Depends on mwem_pkg and mwem_seq.
//
// Each input beat is one tick of the pin sequencer. A read, write, enable,
// disable or erase-all command in a beat taken while idle starts a sequence
// of frames; the following beats advance it and supply the sampled device
// data-out pin. Every input beat yields exactly one output beat with the pin
// levels for that tick and the busy, done, read byte and failure status.
// An input beat's output is valid in the next cycle, and a new beat is
// taken every cycle as long as the output register is empty or being drained
// in the same cycle, so sustained throughput is one beat per cycle; it is set
// by the single sequencer state update per tick.
// When the receiver stalls, the result stays in the output register and
// in_tready drops until it is taken; the sequencer does not advance.
// A synchronous active-low reset puts the sequencer in idle with all pins
// low, clears the status, empties the output register and sets the attempt
// limit to 3 and the poll limit to 20. Register writes take effect at once.
module microwire_eeprom_master_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] command, [10:3] address, [18:11] write_data, [19] serial_in
  input  logic [mwem_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] chip_select, [1] serial_clock, [2] serial_out, [3] busy_res,
  // [4] done_res, [12:5] rx_byte, [13] write_failed
  output logic [mwem_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [mwem_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                             step;
  logic                             out_valid_r;
  mwem_pkg::res_t                   res;
  mwem_pkg::res_t                   out_res_r;
  logic [mwem_pkg::ATT_W-1:0]       attempt_limit_r;
  logic [mwem_pkg::POLL_W-1:0]      poll_limit_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  mwem_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .command          (in_tdata[2:0]),
    .address          (in_tdata[10:3]),
    .write_data       (in_tdata[18:11]),
    .serial_in        (in_tdata[19]),
    .attempt_limit    (attempt_limit_r),
    .ready_poll_limit (poll_limit_r),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_limit_r <= mwem_pkg::ATTEMPT_RESET;
      poll_limit_r    <= mwem_pkg::POLL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mwem_pkg::CFG_ATTEMPT) begin
        attempt_limit_r <= cfg_data[mwem_pkg::ATT_W-1:0];
      end else begin
        poll_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted beat did not reach the output register");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a held output beat");

  a_clock_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res.serial_clock |-> (res.chip_select && res.busy_res))
    else $error("serial clock toggled outside a frame");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> (!res.chip_select && !res.busy_res && !res.serial_out))
    else $error("done tick with pins active");

endmodule
